// ===== rtl/ocp_pkg.sv =====
// Package: shared types and constants of the orbit camera position block.
package ocp_pkg;

  localparam int unsigned CordicSteps = 16;

  localparam logic [15:0] RadiusMin   = 16'd26;
  localparam logic [15:0] RadiusReset = 16'd1280;
  localparam int          YawHalf     = 23040;
  localparam int          YawFull     = 46080;
  localparam int          PitchLimit  = 11392;
  localparam logic signed [26:0] Angle90  = 27'sd5898240;
  localparam logic signed [26:0] Angle180 = 27'sd11796480;
  localparam logic signed [17:0] CordicGain = 18'sd39797;
  localparam int          PosLimit    = 65535;

  // yaw reduction: 46080 = 45 * 1024; 92 whole turns lift any yaw sum above zero
  localparam int          YawOffset     = 4239360;
  localparam int          YawFullHi     = 45;
  // floor(x / 45) = (x * 2913) >> 17, exact for x below 10082
  localparam int          YawRecip      = 2913;
  localparam int          YawRecipShift = 17;

  typedef enum logic [2:0] {
    OP_FORWARD  = 3'd0,
    OP_BACKWARD = 3'd1,
    OP_LEFT     = 3'd2,
    OP_RIGHT    = 3'd3,
    OP_UP       = 3'd4,
    OP_DOWN     = 3'd5
  } op_code_t;

  typedef enum logic [0:0] {
    REG_LINEAR_SPEED  = 1'd0,
    REG_ANGULAR_SPEED = 1'd1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_APPLY,
    ST_WRAP,
    ST_PREP_YAW,
    ST_CORDIC_YAW,
    ST_PREP_PITCH,
    ST_CORDIC_PITCH,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ROUND,
    ST_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;
    logic scale;
    logic apply;
    logic wrap;
    logic prep_yaw;
    logic prep_pitch;
    logic cordic_step;
    logic save_yaw;
    logic mul1;
    logic mul2;
    logic mul3;
    logic round_out;
  } ctrl_t;

  // datapath -> controller status
  typedef struct packed {
    logic cordic_last;
  } status_t;

  function automatic logic signed [26:0] atan_deg(input logic [3:0] i);
    case (i)
      4'd0:    atan_deg = 27'sd2949120;
      4'd1:    atan_deg = 27'sd1740967;
      4'd2:    atan_deg = 27'sd919879;
      4'd3:    atan_deg = 27'sd466945;
      4'd4:    atan_deg = 27'sd234379;
      4'd5:    atan_deg = 27'sd117306;
      4'd6:    atan_deg = 27'sd58666;
      4'd7:    atan_deg = 27'sd29335;
      4'd8:    atan_deg = 27'sd14668;
      4'd9:    atan_deg = 27'sd7334;
      4'd10:   atan_deg = 27'sd3667;
      4'd11:   atan_deg = 27'sd1833;
      4'd12:   atan_deg = 27'sd917;
      4'd13:   atan_deg = 27'sd458;
      4'd14:   atan_deg = 27'sd229;
      4'd15:   atan_deg = 27'sd115;
      default: atan_deg = 27'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/orbit_camera_position_top.sv =====
// Top level: orbit camera position block.
//
// Usage: a request (op, amount) enters on in_valid/in_ready. The block moves
// its camera state (radius, yaw, pitch) by the scaled step, normalises it and
// returns the Cartesian position on out_valid/out_ready as pos_x/pos_y/pos_z
// in signed Q8.8.
// Configuration: cfg_we with cfg_index 0 (linear_speed) or 1 (angular_speed)
// and cfg_data; other indexes are ignored. Write only while idle.
// Sequence: after acceptance, scale and normalisation, then two CORDIC
// passes (one shared iterative unit, yaw then pitch), three multiply stages
// and one rounding stage.
// Occupancy: one request at a time, the next taken only after the result
// has left; the shared CORDIC takes most of the time of each request.
// Reset: rst (synchronous) restores radius 5.0, yaw and pitch zero, both
// speeds 1.0, and idles the controller.
// Stall: the result holds on the outputs until taken; no new request is
// accepted until then.
module orbit_camera_position_top import ocp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic signed [15:0] amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z
);

  ctrl_t   ctrl;
  status_t status;
  logic    cfg_hit;

  // indexes above the register list are dropped
  assign cfg_hit = cfg_we && (cfg_index[1] == 1'b0);

  ocp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  ocp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_hit),
    .cfg_index (cfg_index[0]),
    .cfg_data  (cfg_data),
    .op        (op),
    .amount    (amount),
    .ctrl      (ctrl),
    .status    (status),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
  );

  // never ready for a request while a result is pending
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");

  // a result leaves the output stage only by being taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_z))
    else $error("result dropped while stalled");

  // an accepted request never yields a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

endmodule

// ===== rtl/ocp_ctrl.sv =====
// Controller: sequences one request through the datapath.
module ocp_ctrl import ocp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output ctrl_t   ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:         if (in_valid) state_next = ST_SCALE;
      ST_SCALE:        state_next = ST_APPLY;
      ST_APPLY:        state_next = ST_WRAP;
      ST_WRAP:         state_next = ST_PREP_YAW;
      ST_PREP_YAW:     state_next = ST_CORDIC_YAW;
      ST_CORDIC_YAW:   if (status.cordic_last) state_next = ST_PREP_PITCH;
      ST_PREP_PITCH:   state_next = ST_CORDIC_PITCH;
      ST_CORDIC_PITCH: if (status.cordic_last) state_next = ST_MUL1;
      ST_MUL1:         state_next = ST_MUL2;
      ST_MUL2:         state_next = ST_MUL3;
      ST_MUL3:         state_next = ST_ROUND;
      ST_ROUND:        state_next = ST_OUT;
      ST_OUT:          if (out_ready) state_next = ST_IDLE;
      default:         state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.load = in_valid;
      end
      ST_SCALE:        ctrl.scale = 1'b1;
      ST_APPLY:        ctrl.apply = 1'b1;
      ST_WRAP:         ctrl.wrap = 1'b1;
      ST_PREP_YAW:     ctrl.prep_yaw = 1'b1;
      ST_CORDIC_YAW: begin
        ctrl.cordic_step = 1'b1;
        ctrl.save_yaw = status.cordic_last;
      end
      ST_PREP_PITCH:   ctrl.prep_pitch = 1'b1;
      ST_CORDIC_PITCH: ctrl.cordic_step = 1'b1;
      ST_MUL1:         ctrl.mul1 = 1'b1;
      ST_MUL2:         ctrl.mul2 = 1'b1;
      ST_MUL3:         ctrl.mul3 = 1'b1;
      ST_ROUND:        ctrl.round_out = 1'b1;
      ST_OUT:          out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ocp_datapath.sv =====
// Datapath: camera state, speed scaling, normalisation, CORDIC and products.
module ocp_datapath import ocp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [2:0]          op,
  input  logic signed [15:0]  amount,
  input  ctrl_t               ctrl,
  output status_t             status,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z
);

  logic [15:0]        linear_speed, angular_speed;
  logic [15:0]        orbit_radius;
  logic signed [15:0] yaw_angle;
  logic signed [14:0] pitch_angle;

  logic [2:0]         op_q;
  logic signed [15:0] amount_q;
  logic signed [32:0] lin_prod, ang_prod;
  logic signed [24:0] r_work;
  logic signed [24:0] yaw_work;
  logic signed [24:0] pitch_work;
  logic signed [24:0] radius_ext, lin_step, ang_step;

  // CORDIC
  logic signed [26:0] cz;
  logic signed [18:0] cx, cy;
  logic               cflip;
  logic [3:0]         citer;
  logic signed [18:0] sin_yaw, cos_yaw;

  logic signed [55:0] prod_a, prod_b;
  logic signed [36:0] prod_y;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_speed  <= 16'd256;
      angular_speed <= 16'd256;
    end else if (cfg_we) begin
      if (cfg_index == REG_LINEAR_SPEED) linear_speed <= cfg_data;
      else angular_speed <= cfg_data;
    end
  end

  // yaw modulo 46080: offset to non-negative, keep the low ten bits, reduce the
  // upper part modulo 45 by reciprocal multiplication, then fold into (-180, 180]
  logic [23:0]        yu;
  logic [13:0]        yhi;
  logic [25:0]        yq_prod;
  logic [13:0]        yq;
  logic [13:0]        yrem;
  logic signed [24:0] ymod, ym;
  always_comb begin
    yu      = 24'(yaw_work + 25'(YawOffset));
    yhi     = yu[23:10];
    yq_prod = 26'(yhi) * 26'(YawRecip);
    yq      = 14'(yq_prod >> YawRecipShift);
    yrem    = yhi - 14'(yq * 14'(YawFullHi));
    ymod    = 25'({yrem[5:0], yu[9:0]});
    if (ymod > 25'(YawHalf)) ym = ymod - 25'(YawFull);
    else ym = ymod;
  end

  logic signed [26:0] zin;
  logic signed [18:0] dx, dy;
  assign zin = ctrl.prep_yaw ? 27'(yaw_angle) <<< 9 : 27'(pitch_angle) <<< 9;
  assign dx = cy >>> citer;
  assign dy = cx >>> citer;
  assign status.cordic_last = (citer == 4'(CordicSteps - 1));

  assign radius_ext = 25'($signed({1'b0, orbit_radius}));
  assign lin_step   = 25'(lin_prod >>> 8);
  assign ang_step   = 25'(ang_prod >>> 9);

  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_radius <= RadiusReset;
      yaw_angle    <= '0;
      pitch_angle  <= '0;
    end else if (ctrl.wrap) begin
      if (r_work < $signed(25'(RadiusMin))) orbit_radius <= RadiusMin;
      else if (r_work > 25'sd65535) orbit_radius <= 16'hFFFF;
      else orbit_radius <= r_work[15:0];
      yaw_angle <= ym[15:0];
      if (pitch_work > 25'(PitchLimit)) pitch_angle <= 15'(PitchLimit);
      else if (pitch_work < -25'(PitchLimit)) pitch_angle <= -15'(PitchLimit);
      else pitch_angle <= pitch_work[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_q     <= op;
      amount_q <= amount;
    end
    if (ctrl.scale) begin
      lin_prod <= amount_q * $signed({1'b0, linear_speed});
      ang_prod <= amount_q * $signed({1'b0, angular_speed});
    end
    if (ctrl.apply) begin
      case (op_q)
        OP_FORWARD:  r_work <= radius_ext - lin_step;
        OP_BACKWARD: r_work <= radius_ext + lin_step;
        default:     r_work <= radius_ext;
      endcase
      case (op_q)
        OP_LEFT:  yaw_work <= 25'(yaw_angle) + ang_step;
        OP_RIGHT: yaw_work <= 25'(yaw_angle) - ang_step;
        default:  yaw_work <= 25'(yaw_angle);
      endcase
      case (op_q)
        OP_UP:   pitch_work <= 25'(pitch_angle) + ang_step;
        OP_DOWN: pitch_work <= 25'(pitch_angle) - ang_step;
        default: pitch_work <= 25'(pitch_angle);
      endcase
    end
    if (ctrl.prep_yaw || ctrl.prep_pitch) begin
      cx <= 19'(CordicGain);
      cy <= '0;
      citer <= '0;
      if (zin > Angle90) begin
        cz <= zin - Angle180;
        cflip <= 1'b1;
      end else if (zin < -Angle90) begin
        cz <= zin + Angle180;
        cflip <= 1'b1;
      end else begin
        cz <= zin;
        cflip <= 1'b0;
      end
    end else if (ctrl.cordic_step) begin
      citer <= citer + 4'd1;
      if (!cz[26]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_deg(citer);
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_deg(citer);
      end
    end
  end

  // final cos/sin with flip
  logic signed [18:0] fx, fy;
  assign fx = cflip ? -cx : cx;
  assign fy = cflip ? -cy : cy;

  // yaw result is complete the cycle after its last step
  logic save_d;
  always_ff @(posedge clk) begin
    if (rst) save_d <= 1'b0;
    else save_d <= ctrl.save_yaw;
    if (save_d) begin
      sin_yaw <= fy;
      cos_yaw <= fx;
    end
  end

  // products: the first stage forms both radius products, each later stage one; pitch results in fx/fy
  logic signed [36:0] rc_p;
  always_ff @(posedge clk) begin
    if (ctrl.mul1) begin
      rc_p   <= $signed({1'b0, orbit_radius}) * fx;
      prod_y <= $signed({1'b0, orbit_radius}) * fy;
    end
    if (ctrl.mul2) prod_a <= 56'(rc_p) * 56'(cos_yaw);
    if (ctrl.mul3) prod_b <= 56'(rc_p) * 56'(sin_yaw);
  end

  function automatic logic signed [16:0] sat17(input logic signed [48:0] v);
    if (v > 49'sd65535) sat17 = 17'(PosLimit);
    else if (v < -49'sd65535) sat17 = -17'(PosLimit);
    else sat17 = v[16:0];
  endfunction

  logic signed [48:0] rx, rz, ry;
  assign rx = 49'((prod_a + 56'sd2147483648) >>> 32);
  assign rz = 49'((prod_b + 56'sd2147483648) >>> 32);
  assign ry = (49'(prod_y) + 49'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (ctrl.round_out) begin
      pos_x <= sat17(rx);
      pos_y <= sat17(ry);
      pos_z <= sat17(rz);
    end
  end

endmodule
